// ----- design/lse_pkg.sv -----
// lse_pkg: shared types and constants of the log series evaluator.
// No dependencies; used by every module in design/.
package lse_pkg;

   localparam int FRAC_BITS_DEFAULT   = 24;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam int X_W          = 20;   // Q4.16 argument
   localparam int X_FRAC       = 16;
   localparam int SUM_W        = 32;   // signed result
   localparam int TERMS_W      = 16;
   localparam int THRESHOLD_W  = 31;
   localparam int LIMIT_W      = 16;
   localparam int CSR_DATA_W   = 31;
   localparam int CSR_INDEX_W  = 1;
   localparam int PROD_W       = 64;   // |term| * |t|
   localparam int DIV_STEPS    = 4;    // quotient bits per divider cycle

   localparam logic [THRESHOLD_W-1:0] STOP_THRESHOLD_RESET = 31'd1;
   localparam logic [LIMIT_W-1:0]     TERM_LIMIT_RESET     = 16'd4096;

   localparam logic signed [SUM_W-1:0] SUM_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN = 32'sh8000_0000;

   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_THRESHOLD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TERM_LIMIT     = 1'd1;

   typedef enum logic [1:0] {
      STATUS_CONVERGED = 2'd0,
      STATUS_LIMIT     = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;       // take request, set up t, term, sum
      logic       mul;        // product = |term| * |t|
      logic       div_start;  // product / n
      logic       sub;        // magnitude of next term
      logic       acc;        // apply term, count it
      logic       out_load;   // move result to output register
      status_type code;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic converged;
      logic at_limit;
      logic overflow;
      logic div_done;
      logic out_busy;
   } stat_type;

endpackage

// ----- design/lse_divider.sv -----
// lse_divider: iterative restoring divider, DIV_STEPS quotient bits per cycle.
// Depends on lse_pkg.
module lse_divider #(
   parameter int DIVIDEND_W = lse_pkg::PROD_W,
   parameter int DIVISOR_W  = lse_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic                  rem_nonzero,
   output logic                  done
);
   import lse_pkg::*;

   localparam int ITER  = DIVIDEND_W / DIV_STEPS;
   localparam int CNT_W = (ITER > 1) ? $clog2(ITER) : 1;

   logic [DIVIDEND_W-1:0] shreg_ff, shreg_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff, done_ff;

   always_comb begin
      logic [DIVISOR_W:0]    trial;
      logic [DIVIDEND_W-1:0] sr;
      logic [DIVISOR_W-1:0]  r;
      sr = shreg_ff;
      r  = rem_ff;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial = {r, sr[DIVIDEND_W-1]};
         if (trial >= {1'b0, divisor}) begin
            r  = DIVISOR_W'(trial - {1'b0, divisor});
            sr = {sr[DIVIDEND_W-2:0], 1'b1};
         end else begin
            r  = trial[DIVISOR_W-1:0];
            sr = {sr[DIVIDEND_W-2:0], 1'b0};
         end
      end
      shreg_in = sr;
      rem_in   = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ITER - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         shreg_ff <= dividend;
         rem_ff   <= '0;
      end else if (busy_ff) begin
         shreg_ff <= shreg_in;
         rem_ff   <= rem_in;
      end
   end

   assign quotient    = shreg_ff;
   assign rem_nonzero = (rem_ff != '0);
   assign done        = done_ff;

endmodule

// ----- design/lse_datapath.sv -----
// lse_datapath: config registers, term/sum arithmetic, divider and output register.
// Depends on lse_pkg and lse_divider.
module lse_datapath #(
   parameter int FRAC_BITS   = lse_pkg::FRAC_BITS_DEFAULT,
   parameter int COUNT_WIDTH = lse_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lse_pkg::cmd_type                      cmd,
   output lse_pkg::stat_type                     stat,
   input  logic                                  csr_write_enable,
   input  logic [lse_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [lse_pkg::CSR_DATA_W-1:0]        csr_write_data,
   input  logic [lse_pkg::X_W-1:0]               req_x_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [lse_pkg::SUM_W-1:0]      rsp_log_estimate,
   output logic [lse_pkg::TERMS_W-1:0]           rsp_terms_used,
   output logic [1:0]                            rsp_status
);
   import lse_pkg::*;

   localparam int T_W = FRAC_BITS + 6;          // holds x scaled and minus one
   localparam int Q_W = PROD_W - FRAC_BITS;

   logic [THRESHOLD_W-1:0]   stop_threshold_ff;
   logic [LIMIT_W-1:0]       term_limit_ff;
   logic [31:0]              tmag_ff;
   logic                     t_pos_ff;
   logic signed [SUM_W-1:0]  term_ff, sum_ff;
   logic [COUNT_WIDTH-1:0]   count_ff, cap;
   logic                     overflow_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic [Q_W-1:0]           qmag_ff, qmag_in;
   logic                     rsp_valid_ff;
   logic signed [SUM_W-1:0]  log_estimate_ff;
   logic [TERMS_W-1:0]       terms_used_ff;
   logic [1:0]               status_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         stop_threshold_ff <= STOP_THRESHOLD_RESET;
         term_limit_ff     <= TERM_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_STOP_THRESHOLD: stop_threshold_ff <= csr_write_data;
            CSR_TERM_LIMIT:     term_limit_ff     <= csr_write_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // effective term cap: zero acts as one, clamp to counter range
   logic [31:0] lim32, cmax32;
   always_comb begin
      lim32  = (term_limit_ff == '0) ? 32'd1 : 32'(term_limit_ff);
      cmax32 = (32'd1 << COUNT_WIDTH) - 32'd1;
      cap    = COUNT_WIDTH'((lim32 > cmax32) ? cmax32 : lim32);
   end

   // t = x - 1 in Q.FRAC_BITS
   logic signed [T_W-1:0] t_s;
   logic signed [63:0]    t64;
   logic signed [31:0]    t32;
   logic                  t_in_range;
   always_comb begin
      t_s        = signed'(T_W'(req_x_value) << (FRAC_BITS - X_FRAC))
                 - signed'(T_W'(1) << FRAC_BITS);
      t64        = 64'(t_s);
      t32        = t64[31:0];
      t_in_range = (t64 <= 64'sh7FFF_FFFF) && (t64 >= -64'sh8000_0000);
   end

   logic [31:0] mag;
   logic        new_neg;
   assign mag     = term_ff[31] ? 32'(-term_ff) : 32'(term_ff);
   assign new_neg = term_ff[31] != t_pos_ff;

   // divider: product / n, n = count + 1
   logic [PROD_W-1:0] quotient;
   logic              rem_nonzero, div_done;

   lse_divider #(
      .DIVIDEND_W (PROD_W),
      .DIVISOR_W  (COUNT_WIDTH)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.div_start),
      .dividend    (prod_ff),
      .divisor     (count_ff + 1'b1),
      .quotient    (quotient),
      .rem_nonzero (rem_nonzero),
      .done        (div_done)
   );

   // floor(a*(n-1)/n) = a - ceil(a/n), then drop fraction
   logic [PROD_W-1:0] diff;
   assign diff    = prod_ff - (quotient + PROD_W'(rem_nonzero));
   assign qmag_in = Q_W'(diff >> FRAC_BITS);

   logic                    term_ovf;
   logic signed [SUM_W-1:0] term_next;
   logic signed [SUM_W:0]   sum_wide;
   always_comb begin
      term_ovf  = new_neg ? (qmag_ff > Q_W'(64'h8000_0000))
                          : (qmag_ff > Q_W'(64'h7FFF_FFFF));
      term_next = new_neg ? -signed'(qmag_ff[31:0]) : signed'(qmag_ff[31:0]);
      sum_wide  = {sum_ff[SUM_W-1], sum_ff} + {term_next[SUM_W-1], term_next};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         count_ff    <= COUNT_WIDTH'(1);
         overflow_ff <= !t_in_range;
         term_ff     <= t32;
         t_pos_ff    <= t64 > 64'sd0;
         tmag_ff     <= t32[31] ? 32'(-t32) : 32'(t32);
         if (t_in_range) sum_ff <= t32;
         else            sum_ff <= (t64 > 64'sd0) ? SUM_MAX : SUM_MIN;
      end else if (cmd.acc) begin
         count_ff <= count_ff + 1'b1;
         if (term_ovf) begin
            overflow_ff <= 1'b1;
            sum_ff      <= new_neg ? SUM_MIN : SUM_MAX;
         end else begin
            term_ff <= term_next;
            if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
               overflow_ff <= 1'b1;
               sum_ff      <= sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
            end else begin
               sum_ff <= sum_wide[SUM_W-1:0];
            end
         end
      end
      if (cmd.mul) prod_ff <= PROD_W'(mag) * PROD_W'(tmag_ff);
      if (cmd.sub) qmag_ff <= qmag_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         log_estimate_ff <= sum_ff;
         terms_used_ff   <= TERMS_W'(count_ff);
         status_ff       <= cmd.code;
      end
   end

   assign stat.converged = mag <= 32'(stop_threshold_ff);
   assign stat.at_limit  = count_ff >= cap;
   assign stat.overflow  = overflow_ff;
   assign stat.div_done  = div_done;
   assign stat.out_busy  = rsp_valid_ff && rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_log_estimate = log_estimate_ff;
   assign rsp_terms_used   = terms_used_ff;
   assign rsp_status       = status_ff;

endmodule

// ----- design/lse_ctrl.sv -----
// lse_ctrl: sequencer for one series evaluation per request.
// Depends on lse_pkg.
module lse_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output lse_pkg::cmd_type  cmd,
   input  lse_pkg::stat_type stat
);
   import lse_pkg::*;

   typedef enum logic [2:0] {
      IDLE, CHECK, DIV_START, DIV_WAIT, SUB, ACC, FINISH
   } state_type;

   state_type  state_ff, state_in;
   status_type code_ff, code_in;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd      = '0;
      cmd.code = code_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CHECK;
            end
         end
         CHECK: begin
            priority if (stat.overflow) begin
               code_in  = STATUS_OVERFLOW;
               state_in = FINISH;
            end else if (stat.converged) begin
               code_in  = STATUS_CONVERGED;
               state_in = FINISH;
            end else if (stat.at_limit) begin
               code_in  = STATUS_LIMIT;
               state_in = FINISH;
            end else begin
               cmd.mul  = 1'b1;
               state_in = DIV_START;
            end
         end
         DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = DIV_WAIT;
         end
         DIV_WAIT: begin
            if (stat.div_done) state_in = SUB;
         end
         SUB: begin
            cmd.sub  = 1'b1;
            state_in = ACC;
         end
         ACC: begin
            cmd.acc  = 1'b1;
            state_in = CHECK;
         end
         FINISH: begin
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         code_ff  <= STATUS_CONVERGED;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   assign req_stall = (state_ff != IDLE);

endmodule

// ----- design/log_series_evaluator_unit.sv -----
// log_series_evaluator_unit: top level, ln(x) by the Taylor series about one.
// Depends on lse_pkg, lse_ctrl, lse_datapath (which holds lse_divider).
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_x_value (Q4.16)
//   rsp      out        rsp_valid/rsp_stall   rsp_log_estimate (Q8.24), rsp_terms_used,
//                                             rsp_status
//   csr      in         csr_write_enable      csr_index, csr_write_data
//
// Each series term takes one 32x32 multiply, the iterative divide by n (4 bits
// a cycle), the ceiling subtract and the accumulate. The number of terms is
// data dependent and bounded by term_limit (a limit of zero acts as one).
// Reset is synchronous, active high; clears the sequencer, output valid and
// the config registers (stop_threshold 1, term_limit 4096).
// req_stall is high while a request is being worked on. The finished result
// sits in an output register, so a new request is taken while rsp_stall holds
// the previous one; it only waits at the end if the register is still full.
module log_series_evaluator_unit #(
   parameter int FRAC_BITS   = lse_pkg::FRAC_BITS_DEFAULT,
   parameter int COUNT_WIDTH = lse_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [lse_pkg::X_W-1:0]           req_x_value,
   // result
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [lse_pkg::SUM_W-1:0]  rsp_log_estimate,
   output logic [lse_pkg::TERMS_W-1:0]       rsp_terms_used,
   output logic [1:0]                        rsp_status,
   // configuration
   input  logic                              csr_write_enable,
   input  logic [lse_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lse_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import lse_pkg::*;

   cmd_type  cmd;    // sequencer commands
   stat_type stat;   // datapath flags back to sequencer

   lse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // all arithmetic, config and output register live here
   lse_datapath #(
      .FRAC_BITS   (FRAC_BITS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_x_value      (req_x_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_log_estimate (rsp_log_estimate),
      .rsp_terms_used   (rsp_terms_used),
      .rsp_status       (rsp_status)
   );

endmodule
